@@ rtl/core/aimag_pkg.sv @@
`default_nettype none

package aimag_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int POS_W         = 32;
	localparam int DIM_W         = 15;
	localparam int REG_IDX_W     = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STEP_X_PIXEL = 3'd0,
		REG_STEP_Y_PIXEL = 3'd1,
		REG_STEP_X_LINE  = 3'd2,
		REG_STEP_Y_LINE  = 3'd3,
		REG_ORIGIN_X     = 3'd4,
		REG_ORIGIN_Y     = 3'd5,
		REG_SRC_WIDTH    = 3'd6,
		REG_SRC_HEIGHT   = 3'd7
	} aimag_reg_e;

	typedef struct packed {
		logic frame_start;
		logic line_start;
	} aimag_in_t;

	typedef struct packed {
		logic [DIM_W-1:0] source_x;
		logic [DIM_W-1:0] source_y;
		logic             inside_res;
	} aimag_out_t;

	typedef struct packed {
		logic [POS_W-1:0] step_x_per_pixel;
		logic [POS_W-1:0] step_y_per_pixel;
		logic [POS_W-1:0] step_x_per_line;
		logic [POS_W-1:0] step_y_per_line;
		logic [POS_W-1:0] origin_x;
		logic [POS_W-1:0] origin_y;
		logic [DIM_W-1:0] source_width;
		logic [DIM_W-1:0] source_height;
	} aimag_cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} aimag_pos_t;

endpackage

`default_nettype wire

@@ rtl/core/aimag_cfg.sv @@
`default_nettype none

module aimag_cfg #(
	parameter int FRAC_BITS = aimag_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [aimag_pkg::REG_IDX_W-1:0]      wr_index,
	input  wire logic [aimag_pkg::POS_W-1:0]          wr_data,
	output aimag_pkg::aimag_cfg_t                     cfg
);
	import aimag_pkg::*;

	localparam logic [POS_W-1:0] ONE_FX = POS_W'(1) << FRAC_BITS;

	aimag_cfg_t cfg_q;
	aimag_reg_e wr_reg;

	assign wr_reg = aimag_reg_e'(wr_index);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_x_per_pixel <= ONE_FX;
			cfg_q.step_y_per_pixel <= '0;
			cfg_q.step_x_per_line  <= '0;
			cfg_q.step_y_per_line  <= ONE_FX;
			cfg_q.origin_x         <= '0;
			cfg_q.origin_y         <= '0;
			cfg_q.source_width     <= '0;
			cfg_q.source_height    <= '0;
		end else if (wr_en) begin
			unique case (wr_reg)
				REG_STEP_X_PIXEL: cfg_q.step_x_per_pixel <= wr_data;
				REG_STEP_Y_PIXEL: cfg_q.step_y_per_pixel <= wr_data;
				REG_STEP_X_LINE:  cfg_q.step_x_per_line  <= wr_data;
				REG_STEP_Y_LINE:  cfg_q.step_y_per_line  <= wr_data;
				REG_ORIGIN_X:     cfg_q.origin_x         <= wr_data;
				REG_ORIGIN_Y:     cfg_q.origin_y         <= wr_data;
				REG_SRC_WIDTH:    cfg_q.source_width     <= wr_data[DIM_W-1:0];
				REG_SRC_HEIGHT:   cfg_q.source_height    <= wr_data[DIM_W-1:0];
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/aimag_pos.sv @@
`default_nettype none

module aimag_pos (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire aimag_pkg::aimag_cfg_t cfg,
	input  wire logic                  in_fire,
	input  wire aimag_pkg::aimag_in_t  pixel,
	input  wire logic                  take,
	output logic                       valid_s1,
	output aimag_pkg::aimag_pos_t      pos_s1
);
	import aimag_pkg::*;

	aimag_pos_t row_q;
	aimag_pos_t cur_q;
	aimag_pos_t row_nx;
	aimag_pos_t sel;
	aimag_pos_t cur_nx;

	// The position used for this pixel is picked first; the current position
	// then steps on from it.
	always_comb begin
		row_nx = row_q;
		sel    = cur_q;
		if (pixel.frame_start) begin
			row_nx.x = cfg.origin_x;
			row_nx.y = cfg.origin_y;
			sel      = row_nx;
		end else if (pixel.line_start) begin
			row_nx.x = row_q.x + cfg.step_x_per_line;
			row_nx.y = row_q.y + cfg.step_y_per_line;
			sel      = row_nx;
		end
		cur_nx.x = sel.x + cfg.step_x_per_pixel;
		cur_nx.y = sel.y + cfg.step_y_per_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			cur_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				row_q    <= row_nx;
				cur_q    <= cur_nx;
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_s1 <= sel;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/aimag_bounds.sv @@
`default_nettype none

module aimag_bounds #(
	parameter int FRAC_BITS = aimag_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire aimag_pkg::aimag_cfg_t cfg,
	input  wire logic                  valid_s1,
	input  wire aimag_pkg::aimag_pos_t pos_s1,
	output logic                       take,
	output logic                       addr_valid,
	input  wire logic                  addr_ready,
	output aimag_pkg::aimag_out_t      addr
);
	import aimag_pkg::*;

	logic [POS_W-1:0] lim_x;
	logic [POS_W-1:0] lim_y;
	aimag_out_t       res;

	// Limits are width and height in the fixed-point scale; a negative
	// position is a large unsigned value and falls outside.
	always_comb begin
		lim_x          = POS_W'(cfg.source_width) << FRAC_BITS;
		lim_y          = POS_W'(cfg.source_height) << FRAC_BITS;
		res.inside_res = (pos_s1.x < lim_x) && (pos_s1.y < lim_y);
		res.source_x   = '0;
		res.source_y   = '0;
		if (res.inside_res) begin
			res.source_x = DIM_W'(pos_s1.x >> FRAC_BITS);
			res.source_y = DIM_W'(pos_s1.y >> FRAC_BITS);
		end
	end

	assign take = !addr_valid || addr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_valid <= 1'b0;
		end else if (take) begin
			addr_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			addr <= res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/affine_inverse_map_address_gen_core.sv @@
// Affine inverse-mapping address generator, nearest neighbor.
// The pixel channel (pixel_valid/pixel_ready/pixel) takes one transaction per
// destination pixel, flagged with frame_start and line_start. The addr channel
// (addr_valid/addr_ready/addr) returns one transaction per pixel, in order:
// the integer source column and row and an inside flag; outside pixels read
// as zero coordinates.
// A pixel accepted on the pixel channel is held in the position tracker
// register, then in the output register, which form a two-deep pipeline.
// Throughput: one pixel per clock while the receiver does not stall. The only
// serial path is the 32-bit row-step add feeding the pixel-step add.
// When the receiver stalls, the result holds in the output register and one
// more pixel may be accepted into the tracker stage; after that pixel_ready
// drops until addr_ready returns.
// Registers are written through wr_en/wr_index/wr_data with no wait; the user
// must write only while no transaction is in flight; the block does not check.
// Reset restores the register defaults (unit steps along x per pixel and y per
// line, zero origin and size), zeroes the positions and empties the pipeline.
`default_nettype none

module affine_inverse_map_address_gen_core #(
	parameter int FRAC_BITS = aimag_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [aimag_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [aimag_pkg::POS_W-1:0]      wr_data,
	input  wire logic                             pixel_valid,
	output logic                                  pixel_ready,
	input  wire aimag_pkg::aimag_in_t             pixel,
	output logic                                  addr_valid,
	input  wire logic                             addr_ready,
	output aimag_pkg::aimag_out_t                 addr
);
	import aimag_pkg::*;

	aimag_cfg_t cfg;
	aimag_pos_t pos_s1;
	logic       valid_s1;
	logic       take;
	logic       in_fire;

	assign pixel_ready = !valid_s1 || take;
	assign in_fire     = pixel_valid && pixel_ready;

	aimag_cfg #(
		.FRAC_BITS (FRAC_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	aimag_pos u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_fire  (in_fire),
		.pixel    (pixel),
		.take     (take),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1)
	);

	aimag_bounds #(
		.FRAC_BITS (FRAC_BITS)
	) u_bounds (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.pos_s1     (pos_s1),
		.take       (take),
		.addr_valid (addr_valid),
		.addr_ready (addr_ready),
		.addr       (addr)
	);

endmodule

`default_nettype wire

@@ rtl/core/aimag_checker.sv @@
`default_nettype none

module aimag_protocol_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             pixel_valid,
	input wire logic                             pixel_ready,
	input wire logic                             addr_valid,
	input wire logic                             addr_ready,
	input wire aimag_pkg::aimag_out_t            addr
);

	// A stalled result keeps its value until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && !addr_ready |=> addr_valid && $stable(addr))
		else $error("addr transaction changed while stalled");

	// An outside pixel reports zero coordinates.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && !addr.inside_res |-> addr.source_x == '0 && addr.source_y == '0)
		else $error("outside pixel with nonzero coordinates");

	// From an empty output, a result appears only for a pixel that passed the tracker register and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(addr_valid) |-> $past(pixel_valid && pixel_ready, 2))
		else $error("result appeared without a matching pixel");

	// The pixel side stalls only when the output register is full.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> addr_valid && !addr_ready)
		else $error("pixel_ready low while the output can drain");

endmodule

bind affine_inverse_map_address_gen_core aimag_protocol_checker u_aimag_checker (.*);

`default_nettype wire
